[rtl/gs2d_pkg.sv]
// ----------------------------------------------------------------------------
// gs2d_pkg
// shared constants and codes for the streaming 2d grid stencil
// ----------------------------------------------------------------------------
package gs2d_pkg;

  localparam int DefMaxCols    = 1024;
  localparam int DefValueWidth = 16;

  localparam int RowW      = 12;
  localparam int GridColsW = 11;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 12;

  localparam logic [RowW-1:0]      RstGridRows = 12'd128;
  localparam logic [GridColsW-1:0] RstGridCols = 11'd128;

  localparam int OutQueueDepth = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STENCIL_KIND = 2'd0,
    CFG_GRID_ROWS    = 2'd1,
    CFG_GRID_COLS    = 2'd2
  } cfg_index_t;

  typedef enum logic {
    KIND_FIVE_POINT = 1'b0,
    KIND_NINE_POINT = 1'b1
  } stencil_kind_t;

endpackage

[rtl/gs2d_if.sv]
// ----------------------------------------------------------------------------
// gs2d_if
// valid/ready channels for grid cells in and stencil results out
// ----------------------------------------------------------------------------
interface gs2d_cell_if import gs2d_pkg::*; #(
  parameter int VALUE_WIDTH = DefValueWidth
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface gs2d_result_if import gs2d_pkg::*; #(
  parameter int VALUE_WIDTH = DefValueWidth,
  parameter int COL_WIDTH   = $clog2(DefMaxCols)
);
  logic                          valid;
  logic                          ready;
  logic [RowW-1:0]               out_row;
  logic [COL_WIDTH-1:0]          out_col;
  logic signed [VALUE_WIDTH-1:0] out_value;
  logic                          on_border;
  logic                          clipped;
  logic                          frame_end;
  logic                          run_last;

  modport source (
    output valid, output out_row, output out_col, output out_value,
    output on_border, output clipped, output frame_end, output run_last,
    input ready
  );
  modport sink (
    input valid, input out_row, input out_col, input out_value,
    input on_border, input clipped, input frame_end, input run_last,
    output ready
  );
endinterface

[rtl/gs2d_ram.sv]
// ----------------------------------------------------------------------------
// gs2d_ram
// simple dual port ram, one write and one registered read-first read
// ----------------------------------------------------------------------------
module gs2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/grid_stencil_2d_streaming_core.sv]
// ----------------------------------------------------------------------------
// grid_stencil_2d_streaming_core
// streaming 5 or 9 point jacobi stencil over raster ordered grid cells
// a cell's results enter the output queue in the cycle after the cell is taken
// throughput: one cell per cycle while the output queue has room, set by the single line store ram read port
// up to two results per cell drain one per cycle while results.ready is high, through an 8 entry queue
// reset: counters, window and queue clear; config returns to mode 0, 128 x 128
// line stores are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module grid_stencil_2d_streaming_core import gs2d_pkg::*; #(
  parameter int MAX_COLS    = DefMaxCols,
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  gs2d_cell_if.sink           cells,
  gs2d_result_if.source       results
);

  localparam int ColW   = $clog2(MAX_COLS);
  localparam int CmpW   = (ColW + 1 > GridColsW) ? ColW + 1 : GridColsW;
  localparam int SumW   = VALUE_WIDTH + 5;
  localparam int QPtrW  = $clog2(OutQueueDepth);
  localparam int QCntW  = QPtrW + 1;
  localparam longint ValHiL = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [SumW-1:0] ValHi = SumW'(ValHiL);
  localparam logic signed [SumW-1:0] ValLo = SumW'(-ValHiL - 64'sd1);

  typedef struct packed {
    logic [RowW-1:0]        row;
    logic [ColW-1:0]        col;
    logic [VALUE_WIDTH-1:0] value;
    logic                   on_border;
    logic                   clipped;
    logic                   frame_end;
    logic                   run_last;
  } res_entry_t;

  // configuration
  stencil_kind_t        stencil_kind;
  logic [RowW-1:0]      grid_rows;
  logic [GridColsW-1:0] grid_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      stencil_kind <= KIND_FIVE_POINT;
      grid_rows    <= RstGridRows;
      grid_cols    <= RstGridCols;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_STENCIL_KIND: stencil_kind <= stencil_kind_t'(cfg_data[0]);
        CFG_GRID_ROWS:    grid_rows    <= cfg_data[RowW-1:0];
        CFG_GRID_COLS:    grid_cols    <= cfg_data[GridColsW-1:0];
        default: ;
      endcase
    end
  end

  // position of the arriving cell
  logic [RowW-1:0] row_count;
  logic [ColW-1:0] col_count;
  logic [RowW-1:0] rows_m1;
  logic [CmpW-1:0] cols_ext, cols_eff, cols_m1, col_ext;
  logic            last_row, last_col, is_interior, is_border;
  logic            accept;

  assign rows_m1  = (grid_rows == '0) ? '0 : grid_rows - 1'b1;
  assign cols_ext = CmpW'(grid_cols);
  assign cols_eff = (cols_ext == '0) ? CmpW'(1) :
                    (cols_ext > CmpW'(MAX_COLS)) ? CmpW'(MAX_COLS) : cols_ext;
  assign cols_m1  = cols_eff - 1'b1;
  assign col_ext  = CmpW'(col_count);

  assign last_row    = row_count >= rows_m1;
  assign last_col    = col_ext >= cols_m1;
  assign is_interior = (row_count >= RowW'(2)) && (col_count >= ColW'(2)) &&
                       (row_count <= rows_m1) && (col_ext <= cols_m1);
  assign is_border   = (row_count == '0) || last_row || (col_count == '0) || last_col;

  assign accept = cells.valid && cells.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + 1'b1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // stage 1 registers
  logic                          s1_valid;
  logic signed [VALUE_WIDTH-1:0] s1_x;
  logic [RowW-1:0]               s1_row;
  logic [ColW-1:0]               s1_col;
  logic                          s1_interior, s1_border, s1_fend;
  logic                          byp_hit;
  logic [2*VALUE_WIDTH-1:0]      byp_data;
  logic [2*VALUE_WIDTH-1:0]      ram_rdata, lines;
  logic signed [VALUE_WIDTH-1:0] above, above2;

  // line stores: upper half previous row, lower half the row before it
  gs2d_ram #(
    .WIDTH (2 * VALUE_WIDTH),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data ({s1_x, above}),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (ram_rdata)
  );

  assign lines  = byp_hit ? byp_data : ram_rdata;
  assign above  = $signed(lines[2*VALUE_WIDTH-1:VALUE_WIDTH]);
  assign above2 = $signed(lines[VALUE_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        byp_hit <= s1_valid && (s1_col == col_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x        <= cells.cell_value;
      s1_row      <= row_count;
      s1_col      <= col_count;
      s1_interior <= is_interior;
      s1_border   <= is_border;
      s1_fend     <= last_row && last_col;
      byp_data    <= {s1_x, above};
    end
  end

  // 3x3 window, top row first, newest column on the right
  logic signed [VALUE_WIDTH-1:0] win [9];
  logic signed [VALUE_WIDTH-1:0] win_next [9];

  always_comb begin
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = above2;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = above;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s1_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  // stencil arithmetic, floor division by arithmetic shift
  logic signed [SumW-1:0] edge_sum, diag_sum, total, quot, sat;
  logic                   clip;

  always_comb begin
    edge_sum = SumW'(win_next[1]) + SumW'(win_next[3]) +
               SumW'(win_next[5]) + SumW'(win_next[7]);
    diag_sum = SumW'(win_next[0]) + SumW'(win_next[2]) +
               SumW'(win_next[6]) + SumW'(win_next[8]);
    total    = (SumW'(win_next[4]) <<< 3) + (edge_sum <<< 1) + diag_sum;
    case (stencil_kind)
      KIND_FIVE_POINT: quot = edge_sum >>> 2;
      KIND_NINE_POINT: quot = total >>> 4;
      default:         quot = edge_sum >>> 2;
    endcase
    clip = 1'b0;
    sat  = quot;
    if (quot > ValHi) begin
      sat  = ValHi;
      clip = 1'b1;
    end else if (quot < ValLo) begin
      sat  = ValLo;
      clip = 1'b1;
    end
  end

  // result entries
  res_entry_t int_entry, brd_entry;

  always_comb begin
    int_entry.row       = s1_row - 1'b1;
    int_entry.col       = s1_col - 1'b1;
    int_entry.value     = sat[VALUE_WIDTH-1:0];
    int_entry.on_border = 1'b0;
    int_entry.clipped   = clip;
    int_entry.frame_end = 1'b0;
    int_entry.run_last  = !s1_border;

    brd_entry.row       = s1_row;
    brd_entry.col       = s1_col;
    brd_entry.value     = s1_x;
    brd_entry.on_border = 1'b1;
    brd_entry.clipped   = 1'b0;
    brd_entry.frame_end = s1_fend;
    brd_entry.run_last  = 1'b1;
  end

  // output queue
  res_entry_t       q_mem [OutQueueDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] q_count;
  logic             push_int, push_brd, pop;
  logic [1:0]       push_n;
  logic [QCntW:0]   q_need;
  res_entry_t       head;

  assign push_int = s1_valid && s1_interior;
  assign push_brd = s1_valid && s1_border;
  assign push_n   = {1'b0, push_int} + {1'b0, push_brd};
  assign pop      = results.valid && results.ready;

  assign q_need      = {1'b0, q_count} + (s1_valid ? (QCntW + 1)'(2) : '0);
  assign cells.ready = q_need <= (QCntW + 1)'(OutQueueDepth - 2);

  always_ff @(posedge clk) begin
    if (push_int) begin
      q_mem[wr_ptr] <= int_entry;
    end
    if (push_brd) begin
      q_mem[wr_ptr + QPtrW'(push_int)] <= brd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      wr_ptr  <= wr_ptr + QPtrW'(push_n);
      rd_ptr  <= rd_ptr + QPtrW'(pop);
      q_count <= q_count + QCntW'(push_n) - QCntW'(pop);
    end
  end

  assign head              = q_mem[rd_ptr];
  assign results.valid     = q_count != '0;
  assign results.out_row   = head.row;
  assign results.out_col   = head.col;
  assign results.out_value = $signed(head.value);
  assign results.on_border = head.on_border;
  assign results.clipped   = head.clipped;
  assign results.frame_end = head.frame_end;
  assign results.run_last  = head.run_last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCntW'(OutQueueDepth))
    else $error("output queue overflow");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col |=> col_count == '0)
    else $error("column counter did not wrap at row end");

  a_bypass_src: assert property (@(posedge clk) disable iff (rst)
    s1_valid && byp_hit |-> $past(s1_valid))
    else $error("line bypass taken without a preceding write");

  a_border_unclipped: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.on_border |-> !results.clipped)
    else $error("border result marked clipped");

  a_frame_end_border: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_end |-> results.on_border && results.run_last)
    else $error("frame end on a non-final result");

endmodule

[tb/sv/grid_stencil_2d_streaming_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_stencil_2d_streaming_core_tb
// self-checking bench for the streaming jacobi stencil: an in-bench line store
// and window model predicts every border pass-through and interior update,
// and each result request is matched in order against the predicted ones
// ----------------------------------------------------------------------------
module grid_stencil_2d_streaming_core_tb;
  import gs2d_pkg::*;

  localparam int MaxCols = DefMaxCols;
  localparam int ValueW  = DefValueWidth;
  localparam int ColW    = $clog2(MaxCols);
  localparam int ValMax  = 2 ** (ValueW - 1) - 1;
  localparam int ValMin  = -(2 ** (ValueW - 1));

  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [ValueW-1:0] value;
    logic              border;
    logic              clip;
    logic              fend;
    logic              last;
  } grid_update_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  cfg_index_t          cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  gs2d_cell_if #(.VALUE_WIDTH(ValueW)) cells_if ();
  gs2d_result_if #(.VALUE_WIDTH(ValueW), .COL_WIDTH(ColW)) results_if ();

  grid_stencil_2d_streaming_core #(
    .MAX_COLS   (MaxCols),
    .VALUE_WIDTH(ValueW)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cells    (cells_if),
    .results  (results_if)
  );

  stencil_kind_t            kind_set;
  int                       rows_set;
  int                       cols_set;
  logic signed [ValueW-1:0] line_prev [MaxCols];
  logic signed [ValueW-1:0] line_prev2 [MaxCols];
  logic signed [ValueW-1:0] win [9];
  int                       row_at;
  int                       col_at;
  grid_update_t             due_updates [$];
  int                       bad_updates;
  bit                       idle_en;
  bit                       hold_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic jacobi_update(input logic signed [ValueW-1:0] x);
    int                       rows;
    int                       cols;
    int                       edges;
    int                       acc;
    int                       res;
    logic signed [ValueW-1:0] up1;
    logic signed [ValueW-1:0] up2;
    bit                       last_r;
    bit                       last_c;
    bit                       inner;
    bit                       rim;
    grid_update_t             upd;
    rows = (rows_set == 0) ? 1 : rows_set;
    cols = (cols_set == 0) ? 1 : cols_set;
    if (cols > MaxCols) cols = MaxCols;
    last_r = row_at >= rows - 1;
    last_c = col_at >= cols - 1;
    up1 = '0;
    up2 = '0;
    if (col_at < MaxCols) begin
      up1 = line_prev[col_at];
      up2 = line_prev2[col_at];
      line_prev2[col_at] = up1;
      line_prev[col_at] = x;
    end
    for (int k = 0; k < 3; k++) begin
      win[3*k] = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = x;
    inner = row_at >= 2 && col_at >= 2 && row_at <= rows - 1 && col_at <= cols - 1;
    rim = row_at == 0 || last_r || col_at == 0 || last_c;
    if (inner) begin
      edges = int'(win[1]) + int'(win[7]) + int'(win[3]) + int'(win[5]);
      if (kind_set == KIND_FIVE_POINT) begin
        res = edges >>> 2;
      end else begin
        acc = 8 * int'(win[4]) + 2 * edges
            + int'(win[0]) + int'(win[2]) + int'(win[6]) + int'(win[8]);
        res = acc >>> 4;
      end
      upd = '0;
      if (res > ValMax) begin
        res = ValMax;
        upd.clip = 1'b1;
      end
      if (res < ValMin) begin
        res = ValMin;
        upd.clip = 1'b1;
      end
      upd.row = RowW'(row_at - 1);
      upd.col = ColW'(col_at - 1);
      upd.value = res[ValueW-1:0];
      upd.last = !rim;
      due_updates.push_back(upd);
    end
    if (rim) begin
      upd = '0;
      upd.row = RowW'(row_at);
      upd.col = ColW'(col_at);
      upd.value = x;
      upd.border = 1'b1;
      upd.fend = last_r && last_c;
      upd.last = 1'b1;
      due_updates.push_back(upd);
    end
    if (last_c) begin
      col_at = 0;
      row_at = last_r ? 0 : row_at + 1;
    end else begin
      col_at = col_at + 1;
    end
  endtask

  function automatic logic [ValueW-1:0] next_cell_value(input int style);
    logic [ValueW-1:0] v;
    case (style)
      1: begin
        if ($urandom_range(0, 1) == 1) v = ValueW'(16'h7fff - $urandom_range(0, 255));
        else v = ValueW'(16'h8000 + $urandom_range(0, 255));
      end
      2: v = ValueW'($urandom_range(0, 63) - 32);
      3: v = ValueW'(16'h7f00 + $urandom_range(0, 255));
      4: v = ValueW'(16'h8000 + $urandom_range(0, 255));
      default: v = ValueW'($urandom_range(0, 16'hffff));
    endcase
    return v;
  endfunction

  task automatic send_cell(input logic [ValueW-1:0] v);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      cells_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    cells_if.valid <= 1'b1;
    cells_if.cell_value <= v;
    do @(posedge clk); while (!cells_if.ready);
    jacobi_update(v);
  endtask

  task automatic drain_results();
    cells_if.valid <= 1'b0;
    while (due_updates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_STENCIL_KIND: kind_set = stencil_kind_t'(data[0]);
      CFG_GRID_ROWS:    rows_set = int'(data[RowW-1:0]);
      CFG_GRID_COLS:    cols_set = int'(data[GridColsW-1:0]);
      default: ;
    endcase
  endtask

  task automatic program_grid(input stencil_kind_t kind, input int rows, input int cols);
    drain_results();
    write_reg(CFG_STENCIL_KIND, CfgDataW'(kind));
    write_reg(CFG_GRID_ROWS, CfgDataW'(rows));
    write_reg(CFG_GRID_COLS, CfgDataW'(cols));
    cfg_write <= 1'b0;
  endtask

  task automatic hold_results(input int cycles);
    hold_on <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_on <= 1'b0;
  endtask

  task automatic report_bad(input string tag, input grid_update_t want, input grid_update_t got);
    if (bad_updates < 10) begin
      $display(
        "%s: expected r%0d c%0d v%0d b%0b s%0b f%0b l%0b, got r%0d c%0d v%0d b%0b s%0b f%0b l%0b",
        tag, want.row, want.col, $signed(want.value), want.border, want.clip,
        want.fend, want.last, got.row, got.col, $signed(got.value), got.border,
        got.clip, got.fend, got.last);
    end
    bad_updates++;
  endtask

  initial begin : result_sink
    int           stall;
    grid_update_t got;
    grid_update_t want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (results_if.valid && results_if.ready) begin
        got = '{row: results_if.out_row, col: results_if.out_col,
                value: results_if.out_value, border: results_if.on_border,
                clip: results_if.clipped, fend: results_if.frame_end,
                last: results_if.run_last};
        if (due_updates.size() == 0) begin
          report_bad("unexpected update", '0, got);
        end else begin
          want = due_updates.pop_front();
          if (got !== want) report_bad("update mismatch", want, got);
        end
      end
      if (hold_on) begin
        results_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        results_if.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 16);
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // floor of a negative neighbour sum, extremes on every border cell
  task automatic test_five_point_floor();
    logic [ValueW-1:0] grid [9];
    grid = '{16'h7fff, 16'h8000, 16'h7fff,
             16'h8000, 16'h0001, 16'h8000,
             16'h7fff, 16'h7fff, 16'h7fff};
    program_grid(KIND_FIVE_POINT, 3, 3);
    foreach (grid[k]) send_cell(grid[k]);
  endtask

  task automatic test_nine_point_saturation();
    program_grid(KIND_NINE_POINT, 3, 3);
    repeat (9) send_cell(16'h7fff);
    repeat (9) send_cell(16'h8000);
  endtask

  // zero dimensions act as one, fewer than three rows is all border
  task automatic test_degenerate_dims();
    program_grid(KIND_NINE_POINT, 0, 0);
    send_cell(16'h1234);
    program_grid(KIND_FIVE_POINT, 2, 0);
    send_cell(16'h0000);
    send_cell(16'hedcb);
  endtask

  // oversized column count saturates, then a resize lands past the last cell
  // the partial second row leaves both line stores written for narrow frames
  task automatic test_wide_row_resize();
    program_grid(KIND_FIVE_POINT, 4095, 2047);
    repeat (MaxCols + 60) send_cell(next_cell_value(0));
    program_grid(KIND_NINE_POINT, 2, 3);
    repeat (7) send_cell(next_cell_value(0));
  endtask

  task automatic test_tall_column();
    program_grid(KIND_FIVE_POINT, 4095, 1);
    repeat (60) send_cell(next_cell_value(0));
  endtask

  task automatic test_random_frames(input int count, input bit throttle);
    int            done;
    int            rows;
    int            cols;
    int            cells;
    int            style;
    stencil_kind_t kind;
    done = 0;
    while (done < count) begin
      kind = stencil_kind_t'(1'($urandom_range(0, 1)));
      rows = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(3, 24);
      if ($urandom_range(0, 11) == 0) cols = $urandom_range(0, 2);
      program_grid(kind, rows, cols);
      idle_en <= throttle && $urandom_range(0, 3) != 0;
      cells = ((rows == 0) ? 1 : rows) * ((cols == 0) ? 1 : cols);
      // cut frames leave the counters mid frame for the next setting
      if ($urandom_range(0, 7) == 0) cells = $urandom_range(1, cells);
      if (cells > count - done) cells = count - done;
      style = $urandom_range(0, 5);
      repeat (cells) send_cell(next_cell_value(style));
      done += cells;
    end
  endtask

  task automatic test_backpressure();
    program_grid(KIND_NINE_POINT, 6, 30);
    idle_en <= 1'b1;
    fork
      hold_results(400);
      repeat (90) send_cell(next_cell_value(0));
    join
    drain_results();
    repeat (90) send_cell(next_cell_value(1));
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_STENCIL_KIND;
    cfg_data <= '0;
    cells_if.valid <= 1'b0;
    cells_if.cell_value <= '0;
    results_if.ready <= 1'b0;
    idle_en <= 1'b1;
    hold_on <= 1'b0;
    kind_set = KIND_FIVE_POINT;
    rows_set = int'(RstGridRows);
    cols_set = int'(RstGridCols);
    foreach (win[k]) win[k] = '0;
    row_at = 0;
    col_at = 0;
    bad_updates = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_five_point_floor();
    test_nine_point_saturation();
    test_degenerate_dims();
    test_wide_row_resize();
    test_tall_column();
    test_random_frames(150, 1'b1);
    test_backpressure();
    test_random_frames(40, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (bad_updates == 0 && due_updates.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
